FILE: hdl/rrc_pkg.sv
// Package for the region registration cache: field widths, status codes, constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rrc_pkg;
  localparam int unsigned EntriesDef  = 32;
  localparam int unsigned PageBitsDef = 12;
  localparam int unsigned AddrW  = 48;
  localparam int unsigned LenW   = 31;
  localparam int unsigned FpW    = 36;
  localparam int unsigned PagesW = 20;
  localparam int unsigned UsersW = 16;
  localparam int unsigned AgeW   = 32;
  localparam int unsigned BudW   = 40;
  localparam int unsigned UsedW  = 41;
  localparam int unsigned SlotW  = 5;
  localparam logic [BudW-1:0] BudgetReset = 40'd536870912;
  localparam int unsigned RoundPad = 4096;

  typedef enum logic [2:0] {
    ST_HIT = 3'd0, ST_NEW = 3'd1, ST_NOROOM = 3'd2, ST_REFUSED = 3'd3,
    ST_BUDGET = 3'd4, ST_RELEASED = 3'd5, ST_EVICT = 3'd6
  } status_e;
endpackage
`default_nettype wire

FILE: hdl/region_registration_cache_core.sv
// Region registration cache top level: slot table, scan sequencer, output register.
// Depends on rrc_pkg.
// Sequencing: a release result is valid in the cycle after its transfer; a hit on slot i
// ends a one-slot-per-cycle scan; a miss without eviction runs the hit scan and then the
// free-slot scan. Each eviction adds an idle scan, and a free-slot scan unless it was for
// budget; output stalls can hold the decide and evict steps as well.
// One item at a time; the shared compare unit visits one slot per cycle.
// Reset: all slots invalid, age and budget usage zero, size budget 536870912.
`timescale 1ns / 1ps
`default_nettype none
module region_registration_cache_core #(
  parameter int unsigned ENTRIES   = rrc_pkg::EntriesDef,
  parameter int unsigned PAGE_BITS = rrc_pkg::PageBitsDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [39:0]  cfg_wdata_i,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // tdata: action[0], address[48:1], length[79:49], device_ok[80], entry[85:81]
  input  wire logic [87:0]  s_axis_tdata_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // tdata: status[2:0], slot[7:3], first_page[43:8], page_count[63:44]
  output logic [63:0]       m_axis_tdata_o,
  output logic              m_axis_tlast_o
);
  import rrc_pkg::*;
  localparam int unsigned IdxW = $clog2(ENTRIES);
  localparam int unsigned CntW = $clog2(ENTRIES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_REL, S_HSCAN, S_FSCAN, S_DECIDE, S_ESCAN, S_EDO, S_OUT
  } state_e;
  typedef enum logic [1:0] {EV_FREE, EV_BUDGET, EV_REFUSE} why_e;

  // slot table; valid bits in flip-flops, contents undefined until written
  logic [ENTRIES-1:0] valid_q;
  logic [FpW-1:0]    fp_q    [ENTRIES];
  logic [PagesW-1:0] pg_q    [ENTRIES];
  logic [UsersW-1:0] users_q [ENTRIES];
  logic [AgeW-1:0]   age_q   [ENTRIES];
  logic [AgeW-1:0]   agecnt_q;
  logic [UsedW-1:0]  used_q;
  logic [BudW-1:0]   budget_q;

  state_e state_q;
  why_e   why_q;
  logic [CntW-1:0] idx_q;
  logic            found_q;
  logic [IdxW-1:0] best_q, free_q;
  logic [FpW-1:0]  rfp_q;
  logic [PagesW-1:0] rpg_q;
  logic [UsedW-1:0] need_q;
  logic            ok_q;
  logic [AgeW-1:0] stamp_q;
  logic            ovalid_q, olast_q;
  logic [2:0]      ost_q;
  logic [SlotW-1:0] oslot_q;
  logic [FpW-1:0]  ofp_q;
  logic [PagesW-1:0] opg_q;

  // request decode
  logic [AddrW-1:0] in_addr;
  logic [LenW-1:0]  in_len;
  logic [SlotW-1:0] in_entry;
  logic [LenW:0]    span;
  logic [LenW:0]    np_raw;
  logic [PagesW-1:0] np_sat;
  logic [UsedW-1:0] rsize, need_raw;
  logic [IdxW-1:0]  cur;
  assign in_addr  = s_axis_tdata_i[48:1];
  assign in_len   = s_axis_tdata_i[79:49];
  assign in_entry = s_axis_tdata_i[85:81];
  assign span = (LenW+1)'(in_addr[PAGE_BITS-1:0]) + (LenW+1)'(in_len);
  assign np_raw = (span >> PAGE_BITS) + (LenW+1)'(|span[PAGE_BITS-1:0]);
  assign np_sat = (np_raw > (LenW+1)'({PagesW{1'b1}})) ? {PagesW{1'b1}}
                                                       : np_raw[PagesW-1:0];
  assign cur = idx_q[IdxW-1:0];

  // round (pages << PAGE_BITS) + pad up to a power of two
  function automatic logic [UsedW-1:0] round_up(input logic [UsedW-1:0] s);
    logic [UsedW-1:0] v;
    v = s - 1'b1;
    v = v | (v >> 1); v = v | (v >> 2); v = v | (v >> 4);
    v = v | (v >> 8); v = v | (v >> 16); v = v | (v >> 32);
    return v + 1'b1;
  endfunction
  assign need_raw = round_up((UsedW'(np_sat) << PAGE_BITS) + UsedW'(RoundPad));
  assign rsize = round_up((UsedW'(pg_q[best_q]) << PAGE_BITS) + UsedW'(RoundPad));

  logic over;
  assign over = (need_q + used_q) >= UsedW'(budget_q);
  logic ent_ok;
  assign ent_ok = (32'(in_entry) < ENTRIES);
  logic [IdxW-1:0] ent_idx;
  assign ent_idx = in_entry[IdxW-1:0];

  assign s_axis_tready_o = (state_q == S_IDLE) && !ovalid_q;
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tlast_o  = olast_q;
  assign m_axis_tdata_o  = {opg_q, ofp_q, oslot_q, ost_q};

  // sequencer, table and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      valid_q  <= '0;
      agecnt_q <= '0;
      used_q   <= '0;
      budget_q <= BudgetReset;
      ovalid_q <= 1'b0;
      idx_q    <= '0;
      found_q  <= 1'b0;
      why_q    <= EV_FREE;
    end else begin
      if (cfg_we_i) budget_q <= cfg_wdata_i;
      if (ovalid_q && m_axis_tready_i) ovalid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i && s_axis_tready_o) begin
            if (s_axis_tdata_i[0]) begin
              ost_q <= ST_RELEASED; oslot_q <= in_entry; olast_q <= 1'b1;
              if (ent_ok && valid_q[ent_idx]) begin
                ofp_q <= fp_q[ent_idx]; opg_q <= pg_q[ent_idx];
                if (users_q[ent_idx] != '0) users_q[ent_idx] <= users_q[ent_idx] - 1'b1;
              end else begin
                ofp_q <= '0; opg_q <= '0;
              end
              ovalid_q <= 1'b1;
            end else begin
              rfp_q  <= FpW'(in_addr >> PAGE_BITS);
              rpg_q  <= np_sat;
              need_q <= need_raw;
              ok_q   <= s_axis_tdata_i[80];
              idx_q  <= '0;
              found_q <= 1'b0;
              state_q <= S_HSCAN;
            end
          end
        end
        // hit search, one slot per cycle
        S_HSCAN: begin
          if (idx_q == CntW'(ENTRIES)) begin
            idx_q <= '0; state_q <= S_FSCAN;
          end else if (valid_q[cur] && fp_q[cur] == rfp_q && pg_q[cur] >= rpg_q) begin
            age_q[cur] <= agecnt_q; agecnt_q <= agecnt_q + 1'b1;
            if (users_q[cur] != '1) users_q[cur] <= users_q[cur] + 1'b1;
            ost_q <= ST_HIT; oslot_q <= SlotW'(cur); ofp_q <= fp_q[cur];
            opg_q <= pg_q[cur]; olast_q <= 1'b1; ovalid_q <= 1'b1;
            state_q <= S_IDLE;
          end else idx_q <= idx_q + 1'b1;
        end
        // lowest free slot, one slot per cycle
        S_FSCAN: begin
          if (idx_q == CntW'(ENTRIES)) begin
            why_q <= EV_FREE; idx_q <= '0; found_q <= 1'b0; state_q <= S_ESCAN;
          end else if (!valid_q[cur]) begin
            free_q <= cur; stamp_q <= agecnt_q; agecnt_q <= agecnt_q + 1'b1;
            state_q <= S_DECIDE;
          end else idx_q <= idx_q + 1'b1;
        end
        S_DECIDE: begin
          if (over) begin
            why_q <= EV_BUDGET; idx_q <= '0; found_q <= 1'b0; state_q <= S_ESCAN;
          end else if (!ok_q) begin
            why_q <= EV_REFUSE; idx_q <= '0; found_q <= 1'b0; state_q <= S_ESCAN;
          end else if (!ovalid_q) begin
            valid_q[free_q] <= 1'b1; fp_q[free_q] <= rfp_q; pg_q[free_q] <= rpg_q;
            users_q[free_q] <= UsersW'(1); age_q[free_q] <= stamp_q;
            used_q <= used_q + need_q;
            ost_q <= ST_NEW; oslot_q <= SlotW'(free_q); ofp_q <= rfp_q;
            opg_q <= rpg_q; olast_q <= 1'b1; ovalid_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        // oldest idle slot, one slot per cycle
        S_ESCAN: begin
          if (idx_q == CntW'(ENTRIES)) state_q <= S_EDO;
          else begin
            if (valid_q[cur] && users_q[cur] == '0 &&
                (!found_q || age_q[cur] < age_q[best_q])) begin
              best_q <= cur; found_q <= 1'b1;
            end
            idx_q <= idx_q + 1'b1;
          end
        end
        S_EDO: begin
          if (!ovalid_q) begin
            ovalid_q <= 1'b1;
            if (found_q) begin
              ost_q <= ST_EVICT; oslot_q <= SlotW'(best_q); ofp_q <= fp_q[best_q];
              opg_q <= pg_q[best_q]; olast_q <= 1'b0;
              valid_q[best_q] <= 1'b0;
              used_q <= (used_q >= rsize) ? used_q - rsize : '0;
              idx_q <= '0; found_q <= 1'b0;
              state_q <= (why_q == EV_BUDGET) ? S_OUT : S_FSCAN;
            end else begin
              ofp_q <= rfp_q; opg_q <= rpg_q;
              olast_q <= 1'b1; state_q <= S_IDLE;
              case (why_q)
                EV_FREE:   begin ost_q <= ST_NOROOM;  oslot_q <= '0; end
                EV_BUDGET: begin ost_q <= ST_BUDGET;  oslot_q <= SlotW'(free_q); end
                default:   begin ost_q <= ST_REFUSED; oslot_q <= SlotW'(free_q); end
              endcase
            end
          end
        end
        // after a budget eviction: evict again while still over, else check refusal, then decide
        S_OUT: begin
          if (over) begin
            idx_q <= '0; found_q <= 1'b0; state_q <= S_ESCAN;
          end else if (!ok_q) begin
            why_q <= EV_REFUSE; idx_q <= '0; found_q <= 1'b0; state_q <= S_ESCAN;
          end else state_q <= S_DECIDE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // assertions
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tlast_o) |-> (state_q != S_IDLE)) else $error("orphan");
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !m_axis_tvalid_o) else $error("ready while busy");
  a_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q == '0) |-> (used_q == '0) || $past(valid_q) != '0) else $error("used");
endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// Testbench for region_registration_cache_core: directed and random register and
// release requests, checked transfer by transfer against an in-bench cache predictor.
// Depends on rrc_pkg and the core RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import rrc_pkg::*;

  localparam int unsigned NSlots = 32;
  localparam int unsigned PgBits = 12;
  localparam int unsigned CycleLimit = 3000000;

  typedef struct packed {
    logic [4:0]        entry;
    logic              device_ok;
    logic [LenW-1:0]   length;
    logic [AddrW-1:0]  address;
    logic              action;
  } request_t;

  typedef struct packed {
    logic              last;
    logic [PagesW-1:0] pages;
    logic [FpW-1:0]    fp;
    logic [SlotW-1:0]  slot;
    status_e           status;
  } outcome_t;

  localparam logic ActRegister = 1'b0;
  localparam logic ActRelease  = 1'b1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [BudW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [87:0] in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [63:0] out_data;
  logic out_last;

  region_registration_cache_core u_top (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .s_axis_tvalid_i(in_valid), .s_axis_tready_o(in_ready), .s_axis_tdata_i(in_data),
    .m_axis_tvalid_o(out_valid), .m_axis_tready_i(out_ready), .m_axis_tdata_o(out_data),
    .m_axis_tlast_o(out_last)
  );

  always #4 clk = ~clk;

  // Predictor state
  logic              p_valid [NSlots];
  logic [FpW-1:0]    p_fp    [NSlots];
  logic [PagesW-1:0] p_pages [NSlots];
  logic [UsersW-1:0] p_users [NSlots];
  logic [AgeW-1:0]   p_age   [NSlots];
  logic [AgeW-1:0]   age_ctr;
  logic [UsedW-1:0]  used;
  logic [BudW-1:0]   budget;

  request_t pending_reqs[$];
  outcome_t expected_outcomes[$];
  int mismatches = 0;
  int transfers_in = 0, results_seen = 0, evictions_seen = 0;
  longint cycles = 0;

  function automatic logic [63:0] round_up(logic [PagesW-1:0] np);
    logic [63:0] s, p;
    s = ({44'd0, np} << PgBits) + RoundPad;
    p = 64'd1;
    if ((s & (s - 1)) == 0) return s;
    while (p < s) p = p << 1;
    return p;
  endfunction

  function automatic void push(status_e st, int sl, logic [FpW-1:0] fp,
                               logic [PagesW-1:0] np, logic lst);
    outcome_t o;
    o.status = st; o.slot = sl[SlotW-1:0]; o.fp = fp; o.pages = np; o.last = lst;
    expected_outcomes.push_back(o);
  endfunction

  // Evict the oldest idle slot; 0 if none
  function automatic bit evict_oldest();
    int best;
    logic [63:0] sh;
    best = -1;
    for (int i = 0; i < NSlots; i++)
      if (p_valid[i] && p_users[i] == 0)
        if (best < 0 || p_age[i] < p_age[best]) best = i;
    if (best < 0) return 1'b0;
    push(ST_EVICT, best, p_fp[best], p_pages[best], 1'b0);
    p_valid[best] = 1'b0;
    sh = round_up(p_pages[best]);
    used = (used >= sh) ? used - sh[UsedW-1:0] : '0;
    return 1'b1;
  endfunction

  function automatic void predict_cache(request_t r);
    logic [FpW-1:0] fp;
    logic [63:0] span, np64, need;
    logic [PagesW-1:0] np;
    int s;
    logic [AgeW-1:0] stamp;
    if (r.action == ActRelease) begin
      if (p_valid[r.entry]) begin
        if (p_users[r.entry] > 0) p_users[r.entry]--;
        push(ST_RELEASED, r.entry, p_fp[r.entry], p_pages[r.entry], 1'b1);
      end else push(ST_RELEASED, r.entry, '0, '0, 1'b1);
      return;
    end
    fp = FpW'(r.address >> PgBits);
    span = {52'd0, r.address[PgBits-1:0]} + {33'd0, r.length};
    np64 = (span >> PgBits) + ((span[PgBits-1:0] != 0) ? 64'd1 : 64'd0);
    np = (np64 > 64'hFFFFF) ? 20'hFFFFF : np64[PagesW-1:0];
    for (int i = 0; i < NSlots; i++)
      if (p_valid[i] && p_fp[i] == fp && p_pages[i] >= np) begin
        p_age[i] = age_ctr;
        age_ctr++;
        if (p_users[i] != 16'hFFFF) p_users[i]++;
        push(ST_HIT, i, p_fp[i], p_pages[i], 1'b1);
        return;
      end
    need = round_up(np);
    forever begin
      s = -1;
      for (int i = 0; i < NSlots; i++)
        if (!p_valid[i] && s < 0) s = i;
      if (s < 0) begin
        if (!evict_oldest()) begin
          push(ST_NOROOM, 0, fp, np, 1'b1);
          return;
        end
        continue;
      end
      stamp = age_ctr;
      age_ctr++;
      while (need + used >= budget)
        if (!evict_oldest()) begin
          push(ST_BUDGET, s, fp, np, 1'b1);
          return;
        end
      if (!r.device_ok) begin
        if (!evict_oldest()) begin
          push(ST_REFUSED, s, fp, np, 1'b1);
          return;
        end
        continue;
      end
      p_valid[s] = 1'b1; p_fp[s] = fp; p_pages[s] = np; p_users[s] = 1; p_age[s] = stamp;
      used = used + need[UsedW-1:0];
      push(ST_NEW, s, fp, np, 1'b1);
      return;
    end
  endfunction

  // Driver: present queued requests with random gaps
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_cache(request_t'(in_data[85:0]));
        transfers_in++;
        void'(pending_reqs.pop_front());
        send_gap = $urandom_range(0, 4);
      end
      if (in_valid && in_ready && (send_gap != 0 || pending_reqs.size() == 0)) begin
        in_valid <= 1'b0;
      end else if (!(in_valid && !in_ready)) begin
        if (send_gap > 0) send_gap--;
        else if (pending_reqs.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= {2'b00, pending_reqs[0]};
        end else in_valid <= 1'b0;
      end
    end
  end

  // Monitor: random back-pressure and comparison
  int recv_gap = 0;
  always @(posedge clk) begin
    outcome_t got, want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = outcome_t'({out_last, out_data[63:0]});
        results_seen++;
        if (got.status == ST_EVICT) evictions_seen++;
        if (expected_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          want = expected_outcomes.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp st=%0d sl=%0d fp=%h pg=%h l=%b / got st=%0d sl=%0d fp=%h pg=%h l=%b",
                       want.status, want.slot, want.fp, want.pages, want.last,
                       got.status, got.slot, got.fp, got.pages, got.last);
          end
        end
        recv_gap = $urandom_range(0, 4);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else out_ready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic request_t reg_req(logic [AddrW-1:0] a, logic [LenW-1:0] l, logic ok);
    request_t r;
    r.action = ActRegister; r.address = a; r.length = l; r.device_ok = ok;
    r.entry = 5'($urandom);
    return r;
  endfunction

  function automatic request_t rel_req(int e);
    request_t r;
    r = request_t'(86'({$urandom, $urandom, $urandom}));
    r.action = ActRelease; r.entry = e[4:0];
    return r;
  endfunction

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_outcomes.size() > 0) @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  task automatic set_budget(logic [BudW-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    budget = v;
  endtask

  task automatic random_phase(int n);
    logic [AddrW-1:0] pool [8];
    request_t r;
    for (int i = 0; i < 8; i++) pool[i] = AddrW'({$urandom, $urandom});
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: r = reg_req(pool[$urandom_range(0, 7)], LenW'($urandom_range(0, 40000)),
                                $urandom_range(0, 5) != 0);
        4: r = reg_req(AddrW'({$urandom, $urandom}), LenW'($urandom), 1'($urandom_range(0, 1)));
        5, 6, 7: r = rel_req($urandom_range(0, 31));
        default: r = reg_req(AddrW'({$urandom, $urandom}), LenW'($urandom_range(0, 9000)),
                             1'b1);
      endcase
      pending_reqs.push_back(r);
    end
  endtask

  initial begin
    for (int i = 0; i < NSlots; i++) begin
      p_valid[i] = 0; p_fp[i] = '0; p_pages[i] = '0; p_users[i] = '0; p_age[i] = '0;
    end
    age_ctr = '0; used = '0; budget = BudgetReset;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, hits, refusal, bad release and budget
    pending_reqs.push_back(reg_req('0, '0, 1'b1));
    pending_reqs.push_back(reg_req({AddrW{1'b1}}, {LenW{1'b1}}, 1'b1));
    pending_reqs.push_back(reg_req(48'h1000, 31'd100, 1'b1));
    pending_reqs.push_back(reg_req(48'h1000, 31'd50, 1'b1));
    pending_reqs.push_back(reg_req(48'h1FFF, 31'd2, 1'b1));
    pending_reqs.push_back(reg_req(48'h5000, 31'd10, 1'b0));
    pending_reqs.push_back(rel_req(2));
    pending_reqs.push_back(rel_req(2));
    pending_reqs.push_back(rel_req(2));
    pending_reqs.push_back(rel_req(31));
    pending_reqs.push_back(reg_req(48'h9000, 31'd4096, 1'b0));
    for (int i = 0; i < 12; i++) pending_reqs.push_back(reg_req(48'h100000 + i * 48'h1000, 31'd1, 1'b1));
    drain();

    // Tiny budget: everything is over budget
    set_budget('0);
    for (int i = 0; i < 6; i++) pending_reqs.push_back(rel_req(i));
    random_phase(10);
    drain();

    // Fill the table with held entries, then force no room
    set_budget({BudW{1'b1}});
    for (int i = 0; i < 34; i++) pending_reqs.push_back(reg_req(48'h40000000 + i * 48'h10000, 31'd8, 1'b1));
    drain();
    pending_reqs.push_back(reg_req(48'h7777000, 31'd1, 1'b1));
    pending_reqs.push_back(reg_req(48'h7778000, 31'd1, 1'b0));
    drain();

    set_budget(40'd200000);
    random_phase(70);
    drain();
    set_budget(BudgetReset);
    random_phase(75);
    drain();

    $display("covered %0d requests, %0d results, %0d evictions under five budget settings",
             transfers_in, results_seen, evictions_seen);
    if (mismatches == 0) $display("[ OK ] regression clean");
    else begin
      $display("%0d mismatches", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire
